@@ src/fdbl_pkg.sv @@
// Shared types and constants for the flash die busy-time latency model.
package fdbl_pkg;

  // Field widths of the command and result items
  localparam int KIND_W = 2;
  localparam int TIME_W = 64;
  localparam int CH_W = 3;
  localparam int DIE_W = 3;
  localparam int DELAY_W = 32;
  localparam int COUNT_W = 4;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 32;

  // Channel and die fields are 3 bits, so at most 8 of each are reachable
  localparam int PTR_LIMIT = 8;
  localparam int SLOT_W = CH_W + DIE_W;
  localparam int SLOTS = 1 << SLOT_W;

  localparam logic [DELAY_W-1:0] ER_BUSY_NS_RESET = 32'd2000000;
  localparam logic [COUNT_W-1:0] COUNT_RESET = 4'd8;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_RD_BUSY = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WR_BUSY = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ER_BUSY = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CHANNELS = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_DIES = 3'd4;

  // Command kinds
  typedef enum logic [KIND_W-1:0] {
    KIND_READ = 2'd0,
    KIND_WRITE = 2'd1,
    KIND_ERASE = 2'd2,
    KIND_ADVANCE = 2'd3
  } kind_t;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_ADD,
    ST_OUT
  } state_t;

  // Clamp a programmed count: zero acts as one, large values saturate
  function automatic logic [COUNT_W-1:0] eff_count(input logic [COUNT_W-1:0] v,
                                                   input logic [COUNT_W-1:0] lim);
    logic [COUNT_W-1:0] r;
    if (v == '0) begin
      r = COUNT_W'(1);
    end else if (v > lim) begin
      r = lim;
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

@@ src/fdbl_req_if.sv @@
// Command channel interface: valid/ready handshake with the command fields.
interface fdbl_req_if;
  logic valid;
  logic ready;
  fdbl_pkg::kind_t kind;
  logic [fdbl_pkg::TIME_W-1:0] request_time;
  logic [fdbl_pkg::TIME_W-1:0] current_time;
  logic [fdbl_pkg::CH_W-1:0] channel;
  logic [fdbl_pkg::DIE_W-1:0] die;

  modport source (output valid, kind, request_time, current_time, channel, die,
                  input ready);
  modport sink (input valid, kind, request_time, current_time, channel, die,
                output ready);
endinterface

@@ src/fdbl_rsp_if.sv @@
// Result channel interface: valid/ready handshake with the result fields.
interface fdbl_rsp_if;
  logic valid;
  logic ready;
  logic [fdbl_pkg::TIME_W-1:0] latency;
  logic [fdbl_pkg::CH_W-1:0] pointer_channel;
  logic [fdbl_pkg::DIE_W-1:0] pointer_die;
  logic address_error;

  modport source (output valid, latency, pointer_channel, pointer_die, address_error,
                  input ready);
  modport sink (input valid, latency, pointer_channel, pointer_die, address_error,
                output ready);
endinterface

@@ src/flash_die_busy_latency_model.sv @@
// Flash die busy-time latency model: one command in flight, busy table in RAM.
//
// Each die keeps a busy-until time in a RAM of MAX_CHANNELS*MAX_DIES 64-bit
// entries. A read, write or erase command reads its die's entry, starts at
// the later of the request time (current_time when request_time is zero) and
// that entry, writes back start plus the operation delay and returns the
// latency. A command's result goes through these steps from its accepting edge:
// RAM read at acceptance, start/compare, delay add and write-back, output load.
// Advance-pointer and out-of-range commands skip the RAM and go straight
// to the output load. One command is processed at a time; the next one is
// accepted in the cycle after the previous result is loaded into the output
// register, even if the consumer has not taken it yet. A result that is not
// taken holds the sequencer until the output register frees up.
// Entries never written since reset read as zero via per-die valid flags, so
// no clearing pass is needed after reset.
// Configuration may only be written while no command is in flight.
module flash_die_busy_latency_model #(
  parameter int MAX_CHANNELS = 8,
  parameter int MAX_DIES = 8
) (
  input  logic clk,
  input  logic rst_n,
  fdbl_req_if.sink   in_ch,
  fdbl_rsp_if.source out_ch,
  input  logic                              cfg_we,
  input  logic [fdbl_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [fdbl_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  localparam int DEPTH = MAX_CHANNELS * MAX_DIES;
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [fdbl_pkg::COUNT_W-1:0] CH_LIM =
    fdbl_pkg::COUNT_W'((MAX_CHANNELS < fdbl_pkg::PTR_LIMIT) ? MAX_CHANNELS
                                                             : fdbl_pkg::PTR_LIMIT);
  localparam logic [fdbl_pkg::COUNT_W-1:0] DIE_LIM =
    fdbl_pkg::COUNT_W'((MAX_DIES < fdbl_pkg::PTR_LIMIT) ? MAX_DIES
                                                         : fdbl_pkg::PTR_LIMIT);

  // Configuration registers
  logic [fdbl_pkg::DELAY_W-1:0] rd_busy_ns_r;
  logic [fdbl_pkg::DELAY_W-1:0] wr_busy_ns_r;
  logic [fdbl_pkg::DELAY_W-1:0] er_busy_ns_r;
  logic [fdbl_pkg::COUNT_W-1:0] channels_r;
  logic [fdbl_pkg::COUNT_W-1:0] dies_r;

  // Write pointer
  logic [fdbl_pkg::CH_W-1:0]  ptr_ch_r;
  logic [fdbl_pkg::DIE_W-1:0] ptr_die_r;

  // Sequencer and per-command registers
  fdbl_pkg::state_t state_r, state_nxt;
  logic [fdbl_pkg::SLOTS-1:0]   vld_bits_r;
  logic                         vld_hit_r;
  logic [fdbl_pkg::SLOT_W-1:0]  slot_r;
  logic [AW-1:0]                addr_r;
  logic [fdbl_pkg::TIME_W-1:0]  req_r;
  logic [fdbl_pkg::DELAY_W-1:0] delay_r;
  logic [fdbl_pkg::TIME_W-1:0]  start_r;
  logic [fdbl_pkg::TIME_W-1:0]  diff_r;
  logic [fdbl_pkg::TIME_W-1:0]  lat_r;
  logic                         err_r;

  // Output register
  logic                         out_valid_r;
  logic [fdbl_pkg::TIME_W-1:0]  out_lat_r;
  logic [fdbl_pkg::CH_W-1:0]    out_ptr_ch_r;
  logic [fdbl_pkg::DIE_W-1:0]   out_ptr_die_r;
  logic                         out_err_r;

  // Combinational helpers
  logic [fdbl_pkg::COUNT_W-1:0] nch;
  logic [fdbl_pkg::COUNT_W-1:0] ndie;
  logic                         in_acc;
  logic                         is_access;
  logic                         addr_bad;
  logic [AW-1:0]                in_addr;
  logic [fdbl_pkg::TIME_W-1:0]  rd_data;
  logic [fdbl_pkg::TIME_W-1:0]  busy;
  logic [fdbl_pkg::TIME_W:0]    sub_full;
  logic [fdbl_pkg::TIME_W-1:0]  busy_new;
  logic [fdbl_pkg::TIME_W-1:0]  lat_new;
  logic [fdbl_pkg::COUNT_W-1:0] ptr_ch_inc;
  logic [fdbl_pkg::COUNT_W-1:0] ptr_die_inc;
  logic                         out_free;
  logic                         ram_we;

  assign nch  = fdbl_pkg::eff_count(channels_r, CH_LIM);
  assign ndie = fdbl_pkg::eff_count(dies_r, DIE_LIM);

  assign in_acc    = in_ch.valid && in_ch.ready;
  assign is_access = (in_ch.kind != fdbl_pkg::KIND_ADVANCE);
  assign addr_bad  = ({1'b0, in_ch.channel} >= nch) || ({1'b0, in_ch.die} >= ndie);
  assign in_addr   = AW'(int'(in_ch.channel) * MAX_DIES + int'(in_ch.die));

  assign out_free = !out_valid_r || out_ch.ready;
  assign ram_we   = (state_r == fdbl_pkg::ST_ADD);

  // Busy-until table
  fdbl_ram #(
    .WIDTH (fdbl_pkg::TIME_W),
    .DEPTH (DEPTH)
  ) u_busy_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (addr_r),
    .wdata (busy_new),
    .re    (in_acc && is_access && !addr_bad),
    .raddr (in_addr),
    .rdata (rd_data)
  );

  // Start time and distance from request, borrow marks busy < request
  assign busy     = vld_hit_r ? rd_data : '0;
  assign sub_full = {1'b0, busy} - {1'b0, req_r};

  // Completion time and latency
  assign busy_new = start_r + fdbl_pkg::TIME_W'(delay_r);
  assign lat_new  = diff_r + fdbl_pkg::TIME_W'(delay_r);

  assign ptr_ch_inc  = {1'b0, ptr_ch_r} + fdbl_pkg::COUNT_W'(1);
  assign ptr_die_inc = {1'b0, ptr_die_r} + fdbl_pkg::COUNT_W'(1);

  // Hold configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_busy_ns_r <= '0;
      wr_busy_ns_r <= '0;
      er_busy_ns_r <= fdbl_pkg::ER_BUSY_NS_RESET;
      channels_r   <= fdbl_pkg::COUNT_RESET;
      dies_r       <= fdbl_pkg::COUNT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        fdbl_pkg::CFG_RD_BUSY:  rd_busy_ns_r <= cfg_wdata;
        fdbl_pkg::CFG_WR_BUSY:  wr_busy_ns_r <= cfg_wdata;
        fdbl_pkg::CFG_ER_BUSY:  er_busy_ns_r <= cfg_wdata;
        fdbl_pkg::CFG_CHANNELS: channels_r   <= cfg_wdata[fdbl_pkg::COUNT_W-1:0];
        fdbl_pkg::CFG_DIES:     dies_r       <= cfg_wdata[fdbl_pkg::COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= fdbl_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and handshake outputs
  always_comb begin
    state_nxt   = state_r;
    in_ch.ready = 1'b0;
    case (state_r)
      fdbl_pkg::ST_IDLE: begin
        in_ch.ready = 1'b1;
        if (in_ch.valid) begin
          state_nxt = (is_access && !addr_bad) ? fdbl_pkg::ST_READ : fdbl_pkg::ST_OUT;
        end
      end
      fdbl_pkg::ST_READ: state_nxt = fdbl_pkg::ST_ADD;
      fdbl_pkg::ST_ADD:  state_nxt = fdbl_pkg::ST_OUT;
      fdbl_pkg::ST_OUT: begin
        if (out_free) begin
          state_nxt = fdbl_pkg::ST_IDLE;
        end
      end
      default: state_nxt = fdbl_pkg::ST_IDLE;
    endcase
  end

  // Advance the write pointer and mark written dies
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ptr_ch_r   <= '0;
      ptr_die_r  <= '0;
      vld_bits_r <= '0;
    end else begin
      if (in_acc && !is_access) begin
        if (({1'b0, ptr_ch_r} >= nch) || ({1'b0, ptr_die_r} >= ndie)) begin
          ptr_ch_r  <= '0;
          ptr_die_r <= '0;
        end else if (ptr_ch_inc == nch) begin
          ptr_ch_r  <= '0;
          ptr_die_r <= (ptr_die_inc == ndie) ? '0 : ptr_die_inc[fdbl_pkg::DIE_W-1:0];
        end else begin
          ptr_ch_r <= ptr_ch_inc[fdbl_pkg::CH_W-1:0];
        end
      end
      if (ram_we) begin
        vld_bits_r[slot_r] <= 1'b1;
      end
    end
  end

  // Capture the command, then work out start, completion and latency
  always_ff @(posedge clk) begin
    if (in_acc) begin
      slot_r    <= {in_ch.channel, in_ch.die};
      vld_hit_r <= vld_bits_r[{in_ch.channel, in_ch.die}];
      addr_r    <= in_addr;
      req_r     <= (in_ch.request_time == '0) ? in_ch.current_time : in_ch.request_time;
      case (in_ch.kind)
        fdbl_pkg::KIND_READ:  delay_r <= rd_busy_ns_r;
        fdbl_pkg::KIND_WRITE: delay_r <= wr_busy_ns_r;
        default:              delay_r <= er_busy_ns_r;
      endcase
      err_r <= is_access ? addr_bad
                         : (({1'b0, ptr_ch_r} >= nch) || ({1'b0, ptr_die_r} >= ndie));
      lat_r <= '0;
    end
    if (state_r == fdbl_pkg::ST_READ) begin
      if (sub_full[fdbl_pkg::TIME_W]) begin
        start_r <= req_r;
        diff_r  <= '0;
      end else begin
        start_r <= busy;
        diff_r  <= sub_full[fdbl_pkg::TIME_W-1:0];
      end
    end
    if (ram_we) begin
      lat_r <= lat_new;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == fdbl_pkg::ST_OUT && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == fdbl_pkg::ST_OUT && out_free) begin
      out_lat_r     <= lat_r;
      out_ptr_ch_r  <= ptr_ch_r;
      out_ptr_die_r <= ptr_die_r;
      out_err_r     <= err_r;
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.latency         = out_lat_r;
  assign out_ch.pointer_channel = out_ptr_ch_r;
  assign out_ch.pointer_die     = out_ptr_die_r;
  assign out_ch.address_error   = out_err_r;

endmodule

@@ src/fdbl_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module fdbl_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ src/fdbl_checker.sv @@
// Port-level checks for the flash die busy-time latency model, bound to the top.
module fdbl_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [fdbl_pkg::TIME_W-1:0] out_latency,
  input logic                        out_address_error
);

  // Hold a result until it is taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped before it was taken");

  // Take one item at a time: no accept right after an accept
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("item accepted while another is in flight");

  // Report zero latency for a flagged address
  a_err_zero_lat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_address_error |-> out_latency == '0)
    else $error("nonzero latency on an address error");

endmodule

bind flash_die_busy_latency_model fdbl_checker u_fdbl_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_ch.valid),
  .in_ready          (in_ch.ready),
  .out_valid         (out_ch.valid),
  .out_ready         (out_ch.ready),
  .out_latency       (out_ch.latency),
  .out_address_error (out_ch.address_error)
);
